// File: rtl/ifd_pkg.sv
`default_nettype none

package ifd_pkg;

  localparam int DATA_W = 64;
  localparam int TYPE_W = 3;
  localparam int STAT_W = 2;

  // element type codes
  localparam logic [TYPE_W-1:0] TYPE_INT8   = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_INT16  = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_INT32  = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_INT64  = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_UINT8  = 3'd4;
  localparam logic [TYPE_W-1:0] TYPE_UINT16 = 3'd5;
  localparam logic [TYPE_W-1:0] TYPE_RESET  = TYPE_INT32;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

  // one division in flight, passed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              neg;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] den;
  } lane_t;

  // finished result
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] quotient;
    logic [STAT_W-1:0] status;
  } res_t;

  function automatic logic elem_signed(input logic [TYPE_W-1:0] t);
    elem_signed = !(t inside {TYPE_UINT8, TYPE_UINT16});
  endfunction

  // low element bits, sign or zero extended
  function automatic logic [DATA_W-1:0] elem_extend(input logic [DATA_W-1:0] x,
                                                    input logic [TYPE_W-1:0] t);
    case (t)
      TYPE_INT8:   elem_extend = {{(DATA_W-8){x[7]}}, x[7:0]};
      TYPE_INT16:  elem_extend = {{(DATA_W-16){x[15]}}, x[15:0]};
      TYPE_INT32:  elem_extend = {{(DATA_W-32){x[31]}}, x[31:0]};
      TYPE_UINT8:  elem_extend = {{(DATA_W-8){1'b0}}, x[7:0]};
      TYPE_UINT16: elem_extend = {{(DATA_W-16){1'b0}}, x[15:0]};
      default:     elem_extend = x;
    endcase
  endfunction

  // most negative value of a signed type, extended
  function automatic logic [DATA_W-1:0] elem_smin(input logic [TYPE_W-1:0] t);
    case (t)
      TYPE_INT8:  elem_smin = {{(DATA_W-7){1'b1}}, 7'd0};
      TYPE_INT16: elem_smin = {{(DATA_W-15){1'b1}}, 15'd0};
      TYPE_INT32: elem_smin = {{(DATA_W-31){1'b1}}, 31'd0};
      default:    elem_smin = {1'b1, {(DATA_W-1){1'b0}}};
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/ifd_if.sv
`default_nettype none

interface ifd_req_if;
  logic                        valid;
  logic                        ready;
  logic [ifd_pkg::DATA_W-1:0]  dividend;
  logic [ifd_pkg::DATA_W-1:0]  divisor;
  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface ifd_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ifd_pkg::DATA_W-1:0]  quotient;
  logic [ifd_pkg::STAT_W-1:0]  status;
  modport source (output valid, output quotient, output status, input ready);
  modport sink   (input valid, input quotient, input status, output ready);
endinterface

interface ifd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ifd_pkg::TYPE_W-1:0]  element_type;
  modport source (output valid, output element_type, input ready);
  modport sink   (input valid, input element_type, output ready);
endinterface

`default_nettype wire

// File: rtl/ifd_prep.sv
`default_nettype none

module ifd_prep (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [ifd_pkg::TYPE_W-1:0]  element_type,
  input  wire logic [ifd_pkg::DATA_W-1:0]  dividend,
  input  wire logic [ifd_pkg::DATA_W-1:0]  divisor,
  output ifd_pkg::lane_t                   lo
);

  logic                       sgn;
  logic [ifd_pkg::DATA_W-1:0] a;
  logic [ifd_pkg::DATA_W-1:0] b;
  logic                       an;
  logic                       bn;
  ifd_pkg::lane_t             lane_next;

  always_comb begin
    sgn = ifd_pkg::elem_signed(element_type);
    a   = ifd_pkg::elem_extend(dividend, element_type);
    b   = ifd_pkg::elem_extend(divisor, element_type);
    an  = a[ifd_pkg::DATA_W-1];
    bn  = b[ifd_pkg::DATA_W-1];
    lane_next.valid = in_valid;
    lane_next.neg   = an ^ bn;
    lane_next.rem   = '0;
    lane_next.quo   = an ? (~a + 1'b1) : a;
    lane_next.den   = bn ? (~b + 1'b1) : b;
    if (b == '0) begin
      lane_next.status = ifd_pkg::ST_DIV_ZERO;
    end else if (sgn && a == ifd_pkg::elem_smin(element_type) && b == '1) begin
      lane_next.status = ifd_pkg::ST_OVERFLOW;
    end else begin
      lane_next.status = ifd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo.neg    <= lane_next.neg;
      lo.status <= lane_next.status;
      lo.rem    <= lane_next.rem;
      lo.quo    <= lane_next.quo;
      lo.den    <= lane_next.den;
    end
    if (rst) begin
      lo.valid <= 1'b0;
    end else if (en) begin
      lo.valid <= lane_next.valid;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ifd_cell.sv
`default_nettype none

module ifd_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire ifd_pkg::lane_t li,
  output ifd_pkg::lane_t      lo
);

  logic [ifd_pkg::DATA_W:0]   trial;
  logic [ifd_pkg::DATA_W:0]   diff;
  logic                       take;
  logic [ifd_pkg::DATA_W-1:0] rem_next;
  logic [ifd_pkg::DATA_W-1:0] quo_next;

  // one restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    trial    = {li.rem, li.quo[ifd_pkg::DATA_W-1]};
    diff     = trial - {1'b0, li.den};
    take     = !diff[ifd_pkg::DATA_W];
    rem_next = take ? diff[ifd_pkg::DATA_W-1:0] : trial[ifd_pkg::DATA_W-1:0];
    quo_next = {li.quo[ifd_pkg::DATA_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo.neg    <= li.neg;
      lo.status <= li.status;
      lo.rem    <= rem_next;
      lo.quo    <= quo_next;
      lo.den    <= li.den;
    end
    if (rst) begin
      lo.valid <= 1'b0;
    end else if (en) begin
      lo.valid <= li.valid;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ifd_post.sv
`default_nettype none

module ifd_post (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire ifd_pkg::lane_t li,
  output ifd_pkg::res_t       ro
);

  logic [ifd_pkg::DATA_W-1:0] q;

  // floor: on differing signs negate, and step down once more on a nonzero remainder; flagged results give zero
  always_comb begin
    if (li.status != ifd_pkg::ST_OK) begin
      q = '0;
    end else if (li.neg) begin
      q = ~li.quo + {{(ifd_pkg::DATA_W-1){1'b0}}, (li.rem == '0)};
    end else begin
      q = li.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ro.quotient <= q;
      ro.status   <= li.status;
    end
    if (rst) begin
      ro.valid <= 1'b0;
    end else if (en) begin
      ro.valid <= li.valid;
    end
  end

endmodule

`default_nettype wire

// File: rtl/integer_floor_divider_top.sv
`default_nettype none

// channel | dir | payload                        | handshake
// req     | in  | dividend[63:0], divisor[63:0]  | valid/ready
// rsp     | out | quotient[63:0], status[1:0]    | valid/ready
// cfg     | in  | element_type[2:0]              | valid/ready, ready always high
//
// one request accepted per cycle while the skid slot is empty; each result
// reaches rsp through operand prep, the 64 division cells (one quotient
// bit per cell), floor correction and the output register
// rst (synchronous) empties the pipe and sets element_type to int32
// a stalled rsp fills the skid slot; req.ready drops only while it is full
// and the whole cell row holds still

module integer_floor_divider_top (
  input  wire logic  clk,
  input  wire logic  rst,
  ifd_req_if.sink    req,
  ifd_rsp_if.source  rsp,
  ifd_cfg_if.sink    cfg
);

  logic [ifd_pkg::TYPE_W-1:0] element_type;
  logic                       en;
  ifd_pkg::lane_t             lane [0:ifd_pkg::DATA_W];
  ifd_pkg::res_t              fin;

  // output register and skid slot
  logic                       out_valid;
  logic [ifd_pkg::DATA_W-1:0] out_quotient;
  logic [ifd_pkg::STAT_W-1:0] out_status;
  logic                       skid_valid;
  logic [ifd_pkg::DATA_W-1:0] skid_quotient;
  logic [ifd_pkg::STAT_W-1:0] skid_status;

  // config register, written any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_type <= ifd_pkg::TYPE_RESET;
    end else if (cfg.valid) begin
      element_type <= cfg.element_type;
    end
  end

  // the row advances whenever the skid slot is free
  assign en        = !skid_valid;
  assign req.ready = en;

  // operand extension, magnitudes and error detection
  ifd_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (req.valid),
    .element_type (element_type),
    .dividend     (req.dividend),
    .divisor      (req.divisor),
    .lo           (lane[0])
  );

  // one quotient bit per cell, msb first
  for (genvar k = 0; k < ifd_pkg::DATA_W; k++) begin : g_cell
    ifd_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .li  (lane[k]),
      .lo  (lane[k+1])
    );
  end

  // sign and floor correction
  ifd_post u_post (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .li  (lane[ifd_pkg::DATA_W]),
    .ro  (fin)
  );

  // output register with skid slot behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en && fin.valid) begin
      if (!out_valid || rsp.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_valid && rsp.ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && fin.valid) begin
      if (!out_valid || rsp.ready) begin
        out_quotient <= fin.quotient;
        out_status   <= fin.status;
      end else begin
        skid_quotient <= fin.quotient;
        skid_status   <= fin.status;
      end
    end else if (out_valid && rsp.ready && skid_valid) begin
      out_quotient <= skid_quotient;
      out_status   <= skid_status;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.quotient = out_quotient;
  assign rsp.status   = out_status;

  // skid slot only fills behind a held result
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full with output register empty");

  // a flagged element always carries a zero quotient
  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ifd_pkg::ST_OK) |-> (rsp.quotient == '0))
    else $error("error result with nonzero quotient");

  // an accepted request lands in the prep stage on the next cycle
  a_req_enters : assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> lane[0].valid)
    else $error("accepted request lost at prep stage");

  // a result arrives only when the row moved
  a_out_from_row : assert property (@(posedge clk) disable iff (rst)
    (!out_valid ##1 out_valid) |-> $past(en && fin.valid))
    else $error("result appeared without row advance");

endmodule

`default_nettype wire
